// ----- src/apls_pkg.sv -----
// Package for the active particle Langevin step unit.
// Holds request codes, fixed-point constants and the CORDIC angle table.
`timescale 1ns / 1ps

package apls_pkg;

  localparam logic [1:0] REQ_START  = 2'd0;
  localparam logic [1:0] REQ_STEP   = 2'd1;
  localparam logic [1:0] REQ_FINISH = 2'd2;

  localparam logic [1:0] CFG_STEP_SIZE   = 2'd0;
  localparam logic [1:0] CFG_NOISE_SCALE = 2'd1;
  localparam logic [1:0] CFG_KAPPA_START = 2'd2;
  localparam logic [1:0] CFG_KAPPA_END   = 2'd3;

  localparam int CORDIC_STEPS_DEFAULT = 16;

  localparam logic [23:0] STEP_SIZE_RESET   = 24'd4294967;
  localparam logic [23:0] NOISE_SCALE_RESET = 24'd750298;
  localparam logic [14:0] KAPPA_RESET       = 15'd16384;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [31:0] INV_TWO_PI  = 32'sd683565276;

  function automatic logic signed [33:0] turn_atan(input logic [4:0] k);
    logic signed [33:0] a;
    case (k)
      5'd0: a = 34'sd536870912;  5'd1: a = 34'sd316933406;
      5'd2: a = 34'sd167458907;  5'd3: a = 34'sd85004756;
      5'd4: a = 34'sd42667331;   5'd5: a = 34'sd21354465;
      5'd6: a = 34'sd10679838;   5'd7: a = 34'sd5340245;
      5'd8: a = 34'sd2670163;    5'd9: a = 34'sd1335087;
      5'd10: a = 34'sd667544;    5'd11: a = 34'sd333772;
      5'd12: a = 34'sd166886;    5'd13: a = 34'sd83443;
      5'd14: a = 34'sd41722;     5'd15: a = 34'sd20861;
      5'd16: a = 34'sd10430;     5'd17: a = 34'sd5215;
      5'd18: a = 34'sd2608;      5'd19: a = 34'sd1304;
      5'd20: a = 34'sd652;       5'd21: a = 34'sd326;
      5'd22: a = 34'sd163;       5'd23: a = 34'sd81;
      5'd24: a = 34'sd41;        5'd25: a = 34'sd20;
      5'd26: a = 34'sd10;        5'd27: a = 34'sd5;
      5'd28: a = 34'sd3;         5'd29: a = 34'sd1;
      5'd30: a = 34'sd1;
      default: a = 34'sd0;
    endcase
    return a;
  endfunction

endpackage

// ----- src/active_particle_langevin_step_unit.sv -----
// Top level of the active particle Langevin step unit.
// Uses apls_pkg; holds the sequencer, one shared signed multiplier with a
// registered product, the CORDIC rotator and a bit-serial square root.
`timescale 1ns / 1ps

// One item is taken at a time; in_stall is high until its result is loaded
// into the output register. A step item first forms the squares and the
// energy product, then runs one CORDIC iteration per cycle, then makes twelve
// back-to-back passes through the single registered multiplier, after a step
// that sets up the quadrant and before a step that writes back. A finish
// item runs the energy multiplies and then the 32 two-bit steps of the
// square root. Results sit in an output register, so a stalled result only
// holds the next result back, and the next item can be accepted as soon as
// the result is taken.
module active_particle_langevin_step_unit
  import apls_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         req_type,
  input  logic [14:0]        kappa_value,
  input  logic [15:0]        lambda_value,
  input  logic signed [15:0] noise_x,
  input  logic signed [15:0] noise_y,
  input  logic signed [15:0] noise_heading,
  input  logic signed [31:0] start_x,
  input  logic signed [31:0] start_y,
  input  logic [31:0]        start_heading,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic [31:0]        heading_out,
  output logic signed [31:0] work_total,
  output logic [31:0]        radius,
  output logic               finished,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  // Operand selections of the shared multiplier.
  localparam logic [3:0] OP_XX   = 4'd0;
  localparam logic [3:0] OP_YY   = 4'd1;
  localparam logic [3:0] OP_SWX  = 4'd2;
  localparam logic [3:0] OP_DTX1 = 4'd3;
  localparam logic [3:0] OP_KX   = 4'd4;
  localparam logic [3:0] OP_DTX2 = 4'd5;
  localparam logic [3:0] OP_SWY  = 4'd6;
  localparam logic [3:0] OP_DTY1 = 4'd7;
  localparam logic [3:0] OP_KY   = 4'd8;
  localparam logic [3:0] OP_DTY2 = 4'd9;
  localparam logic [3:0] OP_NX   = 4'd10;
  localparam logic [3:0] OP_NY   = 4'd11;
  localparam logic [3:0] OP_NH   = 4'd12;
  localparam logic [3:0] OP_HD   = 4'd13;
  localparam logic [3:0] OP_DE   = 4'd14;
  localparam logic [3:0] OP_NONE = 4'd15;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_ENERGY = 10'b0000000010,
    S_CORDIC = 10'b0000000100,
    S_MUL    = 10'b0000001000,
    S_SQRT   = 10'b0000010000,
    S_OUT    = 10'b0000100000,
    S_WAIT   = 10'b0001000000,
    S_R2     = 10'b0010000000,
    S_DE     = 10'b0100000000,
    S_WORK   = 10'b1000000000
  } state_t;

  state_t state;

  logic [23:0] step_size, noise_scale;
  logic [14:0] kappa_start, kappa_end, stiffness_now;
  logic signed [31:0] x_reg, y_reg, work_sum;
  logic [31:0] heading_reg;

  logic [1:0] req;
  logic [14:0] k_new;
  logic [15:0] lam;
  logic signed [15:0] nx, ny, nh;
  logic [31:0] rad_val;
  logic fin_val;

  // Shared multiplier with registered product.
  logic signed [36:0] ma;
  logic signed [33:0] mb;
  logic signed [67:0] prod;
  logic [3:0] op;
  logic [CW-1:0] ci;
  logic [5:0] sq_cnt;

  logic signed [33:0] cx, cy, cz, cc, cs;
  logic [1:0] quad, quad_next;
  logic signed [67:0] acc_x, acc_y;
  logic [63:0] r2, r2_sum, sq_rem;
  logic [32:0] sq_res;
  logic load_out;

  logic signed [15:0] dk;
  logic signed [33:0] xs, ys;
  logic [63:0] trial;

  // Shifted products feed straight back as the next operand.
  always_comb begin
    ma = '0;
    mb = '0;
    case (op)
      OP_XX:   begin ma = 37'(x_reg); mb = 34'(x_reg); end
      OP_YY:   begin ma = 37'(y_reg); mb = 34'(y_reg); end
      OP_DE:   begin ma = 37'(r2[63:28]); mb = 34'(dk); end
      OP_SWX:  begin ma = 37'(lam); mb = cc; end
      OP_DTX1: begin ma = 37'(prod >>> 18); mb = 34'(step_size); end
      OP_KX:   begin ma = 37'(stiffness_now); mb = 34'(x_reg); end
      OP_DTX2: begin ma = 37'(prod >>> 12); mb = 34'(step_size); end
      OP_SWY:  begin ma = 37'(lam); mb = cs; end
      OP_DTY1: begin ma = 37'(prod >>> 18); mb = 34'(step_size); end
      OP_KY:   begin ma = 37'(stiffness_now); mb = 34'(y_reg); end
      OP_DTY2: begin ma = 37'(prod >>> 12); mb = 34'(step_size); end
      OP_NX:   begin ma = 37'(noise_scale); mb = 34'(nx); end
      OP_NY:   begin ma = 37'(noise_scale); mb = 34'(ny); end
      OP_NH:   begin ma = 37'(noise_scale); mb = 34'(nh); end
      OP_HD:   begin ma = 37'(prod >>> 8); mb = 34'(INV_TWO_PI); end
      default: ;
    endcase
  end

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    if (v > 68'sd2147483647) return 32'sh7fffffff;
    if (v < -68'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !out_valid;
  assign load_out  = (state == S_OUT) && (!out_valid || !out_stall);

  assign dk = $signed({1'b0, k_new}) - $signed({1'b0, stiffness_now});
  assign xs = cx >>> ci;
  assign ys = cy >>> ci;
  assign trial = {sq_res[31:0], 2'b01} + 64'd0;
  assign r2_sum = r2 + prod[63:0];
  assign quad_next = 2'((heading_reg + 32'h20000000) >> 30);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      step_size <= STEP_SIZE_RESET;
      noise_scale <= NOISE_SCALE_RESET;
      kappa_start <= KAPPA_RESET;
      kappa_end <= KAPPA_RESET;
      stiffness_now <= KAPPA_RESET;
      x_reg <= '0;
      y_reg <= '0;
      heading_reg <= '0;
      work_sum <= '0;
      op <= OP_NONE;
      ci <= '0;
      sq_cnt <= '0;
    end else begin
      prod <= 68'(ma) * 68'(mb);
      if (load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_STEP_SIZE:   step_size <= cfg_data[23:0];
          CFG_NOISE_SCALE: noise_scale <= cfg_data[23:0];
          CFG_KAPPA_START: kappa_start <= cfg_data[14:0];
          CFG_KAPPA_END:   kappa_end <= cfg_data[14:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req <= req_type;
            lam <= lambda_value;
            nx <= noise_x;
            ny <= noise_y;
            nh <= noise_heading;
            k_new <= (req_type == REQ_FINISH) ? kappa_end : kappa_value;
            rad_val <= '0;
            fin_val <= 1'b0;
            if (req_type == REQ_START) begin
              x_reg <= start_x;
              y_reg <= start_y;
              heading_reg <= start_heading;
              stiffness_now <= kappa_start;
              work_sum <= '0;
              state <= S_OUT;
            end else if (req_type == REQ_STEP || req_type == REQ_FINISH) begin
              op <= OP_XX;
              state <= S_ENERGY;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_ENERGY: begin
          // x^2 in flight; next cycle issues y^2.
          op <= OP_YY;
          state <= S_R2;
        end
        S_R2: begin
          r2 <= prod[63:0];
          op <= OP_NONE;
          state <= S_DE;
        end
        S_DE: begin
          // Both squares now known; the energy product issues next.
          r2 <= r2_sum;
          sq_rem <= r2_sum;
          op <= OP_DE;
          state <= S_WORK;
        end
        S_WORK: begin
          if (op == OP_DE) begin
            op <= OP_NONE;
          end else begin
            work_sum <= sat32(68'(work_sum) + (prod >>> 13));
            stiffness_now <= k_new;
            if (req == REQ_FINISH) begin
              sq_res <= '0;
              sq_cnt <= 6'd32;
              state <= S_SQRT;
            end else begin
              quad <= quad_next;
              cz <= 34'($signed(heading_reg - {quad_next, 30'd0}));
              cx <= CORDIC_GAIN;
              cy <= '0;
              ci <= '0;
              state <= S_CORDIC;
            end
          end
        end
        S_CORDIC: begin
          if (!cz[33]) begin
            cx <= cx - ys;
            cy <= cy + xs;
            cz <= cz - turn_atan(5'(ci));
          end else begin
            cx <= cx + ys;
            cy <= cy - xs;
            cz <= cz + turn_atan(5'(ci));
          end
          if (ci == CW'(CORDIC_STEPS - 1)) begin
            op <= OP_NONE;
            state <= S_MUL;
          end
          ci <= ci + 1'b1;
        end
        S_MUL: begin
          // op names the product now being formed; prod holds the previous one.
          case (op)
            OP_NONE: begin
              unique case (quad)
                2'd0: begin cc <= cx; cs <= cy; end
                2'd1: begin cc <= -cy; cs <= cx; end
                2'd2: begin cc <= -cx; cs <= -cy; end
                default: begin cc <= cy; cs <= -cx; end
              endcase
              op <= OP_SWX;
            end
            OP_SWX:  op <= OP_DTX1;
            OP_DTX1: op <= OP_KX;
            OP_KX: begin
              acc_x <= 68'(x_reg) + (prod >>> 32);
              op <= OP_DTX2;
            end
            OP_DTX2: op <= OP_SWY;
            OP_SWY: begin
              acc_x <= acc_x - (prod >>> 32);
              op <= OP_DTY1;
            end
            OP_DTY1: op <= OP_KY;
            OP_KY: begin
              acc_y <= 68'(y_reg) + (prod >>> 32);
              op <= OP_DTY2;
            end
            OP_DTY2: op <= OP_NX;
            OP_NX: begin
              acc_y <= acc_y - (prod >>> 32);
              op <= OP_NY;
            end
            OP_NY: begin
              acc_x <= acc_x + (prod >>> 12);
              op <= OP_NH;
            end
            OP_NH: begin
              acc_y <= acc_y + (prod >>> 12);
              op <= OP_HD;
            end
            OP_HD: begin
              op <= OP_NONE;
              state <= S_WAIT;
            end
            default: op <= OP_NONE;
          endcase
        end
        S_WAIT: begin
          // The heading product is ready now.
          x_reg <= sat32(acc_x);
          y_reg <= sat32(acc_y);
          heading_reg <= heading_reg + prod[59:28];
          state <= S_OUT;
        end
        S_SQRT: begin
          if (sq_cnt == 6'd0) begin
            rad_val <= sq_res[31:0];
            fin_val <= 1'b1;
            state <= S_OUT;
          end else begin
            if ((sq_rem >> (2 * (sq_cnt - 1))) >= {sq_res[31:0], 2'b01}) begin
              sq_rem <= sq_rem - (trial << (2 * (sq_cnt - 1)));
              sq_res <= {sq_res[31:0], 1'b1};
            end else begin
              sq_res <= {sq_res[31:0], 1'b0};
            end
            sq_cnt <= sq_cnt - 1'b1;
          end
        end
        S_OUT: begin
          if (load_out) begin
            pos_x <= x_reg;
            pos_y <= y_reg;
            heading_out <= heading_reg;
            work_total <= work_sum;
            radius <= rad_val;
            finished <= fin_val;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
